[hdl/dcma_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_pkg
// Shared constants and types for the dual-channel moving average filter.
// ----------------------------------------------------------------------------
package dcma_pkg;

  localparam int DEPTH_DEF       = 10;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int OUT_BITS        = 16;
  localparam int COUNT_BITS      = 4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_START,
    S_DIV,
    S_HOLD
  } dcma_state_t;

endpackage
`default_nettype wire

[hdl/dcma_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_in_if
// Sample request channel: one humidity and one temperature sample.
// ----------------------------------------------------------------------------
interface dcma_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] humidity;
  logic signed [SAMPLE_BITS-1:0] temperature;

  modport source (output valid, output humidity, output temperature, input ready);
  modport sink   (input valid, input humidity, input temperature, output ready);
endinterface
`default_nettype wire

[hdl/dcma_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_out_if
// Result request channel: both averages and the number of samples held.
// ----------------------------------------------------------------------------
interface dcma_out_if
  import dcma_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] avg_humidity;
  logic signed [OUT_BITS-1:0] avg_temperature;
  logic [COUNT_BITS-1:0]      samples_held;

  modport source (output valid, output avg_humidity, output avg_temperature,
                  output samples_held, input ready);
  modport sink   (input valid, input avg_humidity, input avg_temperature,
                  input samples_held, output ready);
endinterface
`default_nettype wire

[hdl/dual_channel_moving_average.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dual_channel_moving_average
// Moving average of humidity and temperature over the last DEPTH samples,
// using a sample ring, running sums and a shared serial divider.
// Ready only while idle: a new request is taken only after the previous
//   result has been loaded into the output register.
// Reset: synchronous active-low; clears fill count, position and sums.
//   Ring contents are not cleared.
// ----------------------------------------------------------------------------
module dual_channel_moving_average
  import dcma_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dcma_in_if.sink   in_ch,
  dcma_out_if.source out_ch
);

  localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  dcma_state_t state_r, state_nxt;

  logic                          accept;
  logic                          ring_we;
  logic                          div_start;
  logic                          load_out;
  logic                          div_done;
  logic [2*SAMPLE_BITS-1:0]      ring_rdata;
  logic signed [SAMPLE_BITS-1:0] h_r, t_r;
  logic signed [SAMPLE_BITS-1:0] old_h, old_t;
  logic [ADDR_W-1:0]             pos_r;
  logic [CNT_W-1:0]              fill_r;
  logic                          full;
  logic signed [SUM_W-1:0]       hsum_r, hsum_nxt, tsum_r, tsum_nxt;
  logic [SUM_W-1:0]              hmag, tmag;
  logic [SUM_W-1:0]              hq, tq;
  logic signed [SUM_W:0]         hs, ts;

  logic                          out_valid_r;
  logic signed [OUT_BITS-1:0]    avg_h_r, avg_t_r;
  logic [COUNT_BITS-1:0]         held_r;

  assign accept = in_ch.valid && in_ch.ready;
  assign full   = (fill_r == CNT_W'(DEPTH));
  assign old_h  = ring_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign old_t  = ring_rdata[SAMPLE_BITS-1:0];

  dcma_ring #(
    .DEPTH (DEPTH),
    .WIDTH (2 * SAMPLE_BITS),
    .ADDR_W(ADDR_W)
  ) u_ring (
    .clk  (clk),
    .we   (ring_we),
    .waddr(pos_r),
    .wdata({h_r, t_r}),
    .re   (accept),
    .raddr(pos_r),
    .rdata(ring_rdata)
  );

  dcma_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (fill_r),
    .dividend0(hmag),
    .dividend1(tmag),
    .done     (div_done),
    .quot0    (hq),
    .quot1    (tq)
  );

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    ring_we     = 1'b0;
    div_start   = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = rst_n;
        if (in_ch.valid) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        ring_we   = 1'b1;
        state_nxt = S_START;
      end
      S_START: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    hsum_nxt = hsum_r + SUM_W'(h_r);
    tsum_nxt = tsum_r + SUM_W'(t_r);
    if (full) begin
      hsum_nxt = hsum_nxt - SUM_W'(old_h);
      tsum_nxt = tsum_nxt - SUM_W'(old_t);
    end
    hmag = hsum_r[SUM_W-1] ? SUM_W'(-hsum_r) : SUM_W'(hsum_r);
    tmag = tsum_r[SUM_W-1] ? SUM_W'(-tsum_r) : SUM_W'(tsum_r);
    hs   = hsum_r[SUM_W-1] ? -signed'({1'b0, hq}) : signed'({1'b0, hq});
    ts   = tsum_r[SUM_W-1] ? -signed'({1'b0, tq}) : signed'({1'b0, tq});
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      h_r <= in_ch.humidity;
      t_r <= in_ch.temperature;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      fill_r <= '0;
      hsum_r <= '0;
      tsum_r <= '0;
    end else if (ring_we) begin
      hsum_r <= hsum_nxt;
      tsum_r <= tsum_nxt;
      if (!full) begin
        fill_r <= fill_r + 1'b1;
      end
      if (pos_r == ADDR_W'(DEPTH - 1)) begin
        pos_r <= '0;
      end else begin
        pos_r <= pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      avg_h_r <= OUT_BITS'(hs);
      avg_t_r <= OUT_BITS'(ts);
      held_r  <= COUNT_BITS'(fill_r);
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.avg_humidity    = avg_h_r;
  assign out_ch.avg_temperature = avg_t_r;
  assign out_ch.samples_held    = held_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("fill count above window depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= ADDR_W'(DEPTH - 1))
    else $error("write position out of range");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside divide state");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> fill_r != '0)
    else $error("divide started with empty window");

endmodule
`default_nettype wire

[hdl/dcma_ring.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_ring
// Sample ring memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dcma_ring #(
  parameter int DEPTH  = 10,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/dcma_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dcma_div
// Two-lane restoring divider, one quotient bit per lane per cycle, with a
// shared divisor and step counter.
// ----------------------------------------------------------------------------
module dcma_div #(
  parameter int SUM_W = 20,
  parameter int CNT_W = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CNT_W-1:0] divisor,
  input  wire logic [SUM_W-1:0] dividend0,
  input  wire logic [SUM_W-1:0] dividend1,
  output logic                  done,
  output logic      [SUM_W-1:0] quot0,
  output logic      [SUM_W-1:0] quot1
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  d_r;
  logic [SUM_W-1:0]  q0_r, q0_nxt, q1_r, q1_nxt;
  logic [CNT_W-1:0]  r0_r, r0_nxt, r1_r, r1_nxt;
  logic [CNT_W:0]    t0, t1;

  always_comb begin
    t0 = {r0_r, q0_r[SUM_W-1]};
    t1 = {r1_r, q1_r[SUM_W-1]};
    if (t0 >= {1'b0, d_r}) begin
      r0_nxt = CNT_W'(t0 - {1'b0, d_r});
      q0_nxt = {q0_r[SUM_W-2:0], 1'b1};
    end else begin
      r0_nxt = t0[CNT_W-1:0];
      q0_nxt = {q0_r[SUM_W-2:0], 1'b0};
    end
    if (t1 >= {1'b0, d_r}) begin
      r1_nxt = CNT_W'(t1 - {1'b0, d_r});
      q1_nxt = {q1_r[SUM_W-2:0], 1'b1};
    end else begin
      r1_nxt = t1[CNT_W-1:0];
      q1_nxt = {q1_r[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_W'(SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d_r  <= divisor;
      q0_r <= dividend0;
      q1_r <= dividend1;
      r0_r <= '0;
      r1_r <= '0;
    end else if (busy_r) begin
      q0_r <= q0_nxt;
      q1_r <= q1_nxt;
      r0_r <= r0_nxt;
      r1_r <= r1_nxt;
    end
  end

  assign done  = done_r;
  assign quot0 = q0_r;
  assign quot1 = q1_r;

endmodule
`default_nettype wire
